// ===== rtl/core/efrc_pkg.sv =====
// Package: shared types, codes and CRC helper for the escaped frame receiver.
package efrc_pkg;

	localparam int MAX_LENGTH_BYTES = 2;
	localparam int MAX_CRC_WIDTH    = 32;
	localparam int CW_BITS          = $clog2(MAX_CRC_WIDTH + 1);
	localparam int IDX_BITS         = $clog2(MAX_CRC_WIDTH);

	typedef enum logic [1:0] {
		EV_START   = 2'd0,
		EV_PAYLOAD = 2'd1,
		EV_GOOD    = 2'd2,
		EV_ERROR   = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		ERR_ESCAPE = 2'd0,
		ERR_START  = 2'd1,
		ERR_LENGTH = 2'd2,
		ERR_CRC    = 2'd3
	} error_code_t;

	typedef enum logic [2:0] {
		REG_START   = 3'd0,
		REG_ESCAPE  = 3'd1,
		REG_END     = 3'd2,
		REG_LENBYTES = 3'd3,
		REG_POLY    = 3'd4,
		REG_POLYBITS = 3'd5
	} reg_index_t;

	// Classified byte handed from front to back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_start;
		logic       is_escape;
		logic       is_end;
	} cls_item_t;

	// One result item.
	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  payload_byte;
		logic [15:0] packet_length;
		error_code_t error_code;
	} result_t;

	// Active CRC configuration after clamping.
	typedef struct packed {
		logic [MAX_CRC_WIDTH-1:0] mask;
		logic [MAX_CRC_WIDTH-1:0] poly;
		logic [CW_BITS-1:0]       width;
		logic                     enable;
		logic [15:0]              crc_bytes;
	} crc_cfg_t;

	// Bytewise MSB-first CRC update, variable width (top bit selected by width).
	function automatic logic [MAX_CRC_WIDTH-1:0] crc_byte(
		input logic [MAX_CRC_WIDTH-1:0] rem,
		input logic [7:0]               data,
		input crc_cfg_t                 cfg
	);
		logic [MAX_CRC_WIDTH-1:0] r;
		logic                     top;
		r = rem & cfg.mask;
		for (int i = 7; i >= 0; i--) begin
			top = r[IDX_BITS'(cfg.width - CW_BITS'(1))] ^ data[i];
			r = (r << 1) & cfg.mask;
			if (top) r = r ^ cfg.poly;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/efrc_front.sv =====
// Front end: accepts bytes and classifies special bytes.
module efrc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 s_tlast,
	input  logic [7:0]           start_byte,
	input  logic [7:0]           escape_byte,
	input  logic [7:0]           end_byte,
	output logic                 q_valid,
	input  logic                 q_ready,
	output efrc_pkg::cls_item_t  q_item
);
	import efrc_pkg::*;

	// Two-entry queue toward the back end
	cls_item_t  buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;
	cls_item_t  item;

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = buf_q[rd_ptr_q];
	assign pop      = q_valid && q_ready;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		item.data      = s_tdata;
		item.last      = s_tlast;
		item.is_start  = (s_tdata == start_byte);
		item.is_escape = (s_tdata == escape_byte);
		item.is_end    = (s_tdata == end_byte);
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/core/efrc_back.sv =====
// Back end: packet state, length, CRC and result register.
module efrc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  efrc_pkg::cls_item_t  q_item,
	input  logic [1:0]           length_bytes,
	input  efrc_pkg::crc_cfg_t   crc_cfg,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output efrc_pkg::result_t    m_res
);
	import efrc_pkg::*;

	logic        in_packet_q, after_escape_q, discard_q;
	logic [15:0] decl_len_q, pay_cnt_q;
	logic [1:0]  len_seen_q;
	logic [MAX_CRC_WIDTH-1:0] crc_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        take;
	logic        emit, clr, n_in, n_esc, n_disc, inc_len, feed;
	result_t     res;
	logic [1:0]  nlen;
	logic        esc;
	logic [15:0] good_len;

	// Single output register; next item proceeds while it drains
	assign q_ready  = !out_valid_q || m_tready;
	assign take     = q_valid && q_ready;
	assign m_tvalid = out_valid_q;
	assign m_res    = out_q;

	always_comb begin
		nlen = (length_bytes == 2'd0) ? 2'd1 :
			(length_bytes > 2'(MAX_LENGTH_BYTES)) ? 2'(MAX_LENGTH_BYTES) : length_bytes;
		esc  = after_escape_q;
		emit = 1'b0; clr = 1'b0; inc_len = 1'b0; feed = 1'b0;
		n_in = in_packet_q; n_esc = after_escape_q; n_disc = discard_q;
		res  = '{kind: EV_START, payload_byte: 8'd0, packet_length: 16'd0,
			error_code: ERR_ESCAPE};
		good_len = (decl_len_q > crc_cfg.crc_bytes) ? decl_len_q - crc_cfg.crc_bytes : 16'd0;
		if (discard_q) begin
			if (q_item.last) n_disc = 1'b0;
		end else if (!in_packet_q) begin
			if (q_item.is_start) begin
				n_in = 1'b1; emit = 1'b1;
			end
		end else if (esc && !(q_item.is_start || q_item.is_escape || q_item.is_end)) begin
			emit = 1'b1; clr = 1'b1; res.kind = EV_ERROR; res.error_code = ERR_ESCAPE;
		end else if (!esc && q_item.is_escape) begin
			n_esc = 1'b1;
		end else if (!esc && q_item.is_start) begin
			emit = 1'b1; clr = 1'b1; res.kind = EV_ERROR; res.error_code = ERR_START;
		end else if (!esc && q_item.is_end && pay_cnt_q != decl_len_q) begin
			emit = 1'b1; clr = 1'b1; res.kind = EV_ERROR; res.error_code = ERR_LENGTH;
		end else if (len_seen_q < nlen) begin
			n_esc = 1'b0; inc_len = 1'b1;
		end else if ((esc || !q_item.is_end) && pay_cnt_q >= decl_len_q) begin
			emit = 1'b1; clr = 1'b1; res.kind = EV_ERROR; res.error_code = ERR_LENGTH;
		end else if (!esc && q_item.is_end) begin
			emit = 1'b1; clr = 1'b1;
			if (crc_cfg.enable && ((crc_q & crc_cfg.mask) != '0)) begin
				res.kind = EV_ERROR; res.error_code = ERR_CRC;
			end else begin
				res.kind = EV_GOOD;
				res.packet_length = crc_cfg.enable ? good_len : decl_len_q;
			end
		end else begin
			n_esc = 1'b0; feed = 1'b1; emit = 1'b1;
			res.kind = EV_PAYLOAD; res.payload_byte = q_item.data;
		end
		if (clr) n_disc = !q_item.last;
	end

	// Packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0; after_escape_q <= 1'b0; discard_q <= 1'b0;
			decl_len_q <= '0; pay_cnt_q <= '0; len_seen_q <= '0; crc_q <= '0;
		end else if (take) begin
			discard_q <= n_disc;
			if (clr) begin
				in_packet_q <= 1'b0; after_escape_q <= 1'b0;
				decl_len_q <= '0; pay_cnt_q <= '0; len_seen_q <= '0; crc_q <= '0;
			end else begin
				in_packet_q <= n_in;
				after_escape_q <= n_esc;
				if (inc_len) begin
					if (len_seen_q == 2'd0) decl_len_q <= decl_len_q + {8'd0, q_item.data};
					else decl_len_q <= decl_len_q + {q_item.data, 8'd0};
					len_seen_q <= len_seen_q + 2'd1;
				end
				if (feed) begin
					crc_q <= crc_byte(crc_q, q_item.data, crc_cfg);
					pay_cnt_q <= pay_cnt_q + 16'd1;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (q_ready) out_valid_q <= take && emit;
	end

	always_ff @(posedge clk) begin
		if (take && emit) out_q <= res;
	end

endmodule

// ===== rtl/core/escaped_frame_receiver_crc.sv =====
// Top level: config registers, front classifier, back packet engine.
// A result passes through a front queue entry, then the back end's output register.
// Throughput: one byte per cycle unless the output stalls; CRC/state update sets it.
// A two-entry queue separates classification from packet processing.
// Reset (arst_n low, async) clears packet state, queue and config to defaults.
module escaped_frame_receiver_crc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // chunk_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] payload_byte, [23:8] packet_length, zero pad
	output logic [3:0]  m_tuser,   // [1:0] event_kind, [3:2] error_code
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [32:0] cfg_data
);
	import efrc_pkg::*;

	logic [7:0]  start_q, escape_q, end_q;
	logic [1:0]  lenb_q;
	logic [32:0] poly_q;
	logic [5:0]  pbits_q;
	logic        q_valid, q_ready;
	cls_item_t   q_item;
	crc_cfg_t    crc_cfg;
	result_t     res;
	logic [5:0]  pb;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 8'd2; escape_q <= 8'd16; end_q <= 8'd3;
			lenb_q <= 2'd2; poly_q <= '0; pbits_q <= 6'd17;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START:    start_q  <= cfg_data[7:0];
				REG_ESCAPE:   escape_q <= cfg_data[7:0];
				REG_END:      end_q    <= cfg_data[7:0];
				REG_LENBYTES: lenb_q   <= cfg_data[1:0];
				REG_POLY:     poly_q   <= cfg_data;
				REG_POLYBITS: pbits_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Clamped CRC width and derived mask
	always_comb begin
		pb = (pbits_q < 6'd2) ? 6'd2 :
			(pbits_q > 6'(MAX_CRC_WIDTH + 1)) ? 6'(MAX_CRC_WIDTH + 1) : pbits_q;
		crc_cfg.width     = CW_BITS'(pb - 6'd1);
		crc_cfg.mask      = MAX_CRC_WIDTH'((33'd1 << crc_cfg.width) - 33'd1);
		crc_cfg.poly      = poly_q[MAX_CRC_WIDTH-1:0] & crc_cfg.mask;
		crc_cfg.enable    = (poly_q != '0);
		crc_cfg.crc_bytes = 16'((7'(crc_cfg.width) + 7'd7) >> 3);
	end

	efrc_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.start_byte(start_q), .escape_byte(escape_q), .end_byte(end_q),
		.q_valid, .q_ready, .q_item
	);

	efrc_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.length_bytes(lenb_q), .crc_cfg,
		.m_tvalid, .m_tready, .m_res(res)
	);

	assign m_tdata = {8'd0, res.packet_length, res.payload_byte};
	assign m_tuser = {res.error_code, res.kind};

	// Output only errors carry a nonzero error code
	a_errcode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != EV_ERROR |-> m_tuser[3:2] == 2'd0)
		else $error("error code set on non-error result");
	// Payload byte only on payload events
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != EV_PAYLOAD |-> m_tdata[7:0] == 8'd0)
		else $error("payload byte on non-payload result");
	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed under stall");

endmodule
